@@ design/srft_pkg.sv @@
// Shared types, codes and a helper function for the sequence replay filter table.
package srft_pkg;

  // One stored table entry as held in the entry memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] seq;
    logic [31:0] stamp;
  } srft_entry_t;

  // Configuration registers as seen by the controller.
  typedef struct packed {
    logic [31:0] entry_timeout;
    logic [6:0]  max_entries;
  } srft_cfg_t;

  // Register index on the configuration port.
  typedef logic [0:0] srft_cfg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DECIDE,
    ST_WR_HIT,
    ST_EVICT,
    ST_INSERT,
    ST_DONE
  } srft_state_t;

  // Request types; any other code is an expiry sweep.
  localparam logic [1:0] REQ_CHECK_REQ = 2'd0;
  localparam logic [1:0] REQ_CHECK_REP = 2'd1;

  // Verdict codes.
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [1:0] VERDICT_BAD_SIG = 2'd1;
  localparam logic [1:0] VERDICT_REPLAY  = 2'd2;
  localparam logic [1:0] VERDICT_SWEEP   = 2'd3;

  // Configuration register indexes and reset values.
  localparam srft_cfg_idx_t CFG_IDX_TIMEOUT     = 1'b0;
  localparam srft_cfg_idx_t CFG_IDX_MAX_ENTRIES = 1'b1;
  localparam logic [31:0]   TIMEOUT_RESET       = 32'd1000;
  localparam logic [6:0]    MAX_ENTRIES_RESET   = 7'd64;

  // Saturation point of the sweep removal count.
  localparam logic [7:0] REMOVED_MAX = 8'd255;

  // True if entry a is older than entry b; equal ages go to the smaller key.
  function automatic logic srft_older(input logic [31:0] age_a, input logic [31:0] key_a,
                                      input logic [31:0] age_b, input logic [31:0] key_b);
    logic res;
    if (age_a != age_b) begin
      res = age_a > age_b;
    end else begin
      res = key_a < key_b;
    end
    return res;
  endfunction

endpackage

@@ design/srft_if.sv @@
// Valid/ready channel interfaces for check items and for verdict beats.
interface srft_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        key_address;
  logic signed [31:0] seq_num;
  logic [31:0]        now;
  logic               sig_ok;

  modport source (output valid, req_type, key_address, seq_num, now, sig_ok, input ready);
  modport sink (input valid, req_type, key_address, seq_num, now, sig_ok, output ready);
endinterface

interface srft_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       evicted;
  logic [7:0] removed_count;

  modport source (output valid, verdict, evicted, removed_count, input ready);
  modport sink (input valid, verdict, evicted, removed_count, output ready);
endinterface

@@ design/seq_replay_filter_table_unit.sv @@
// Top level of the anti-replay filter: configuration registers, controller and entry memory.
// Sequence: a check walks its table, then passes the decision state and any write-back
// states before its result is registered; a sweep walks both tables, and a bad signature
// skips the walk.
// Throughput: one item at a time, bounded by the single read port of the entry memory.
// Reset: synchronous; a clearing pass over both tables empties them first.
module seq_replay_filter_table_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  srft_pkg::srft_cfg_idx_t cfg_index,
  input  logic [31:0]           cfg_wdata,
  srft_in_if.sink               in_ch,
  srft_out_if.source            out_ch
);
  import srft_pkg::*;

  localparam int SLOTS = 2 * TABLE_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  srft_cfg_t     cfg_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  srft_entry_t   mem_wdata, mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_timeout <= TIMEOUT_RESET;
      cfg_r.max_entries   <= MAX_ENTRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_TIMEOUT:     cfg_r.entry_timeout <= cfg_wdata;
        CFG_IDX_MAX_ENTRIES: cfg_r.max_entries   <= cfg_wdata[6:0];
        default:             cfg_r.entry_timeout <= cfg_r.entry_timeout;
      endcase
    end
  end

  // Sequencer over both tables.
  srft_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Request table in the lower half, reply table in the upper half.
  srft_mem #(
    .ENTRIES (SLOTS),
    .AW      (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ design/srft_mem.sv @@
// Entry memory: one write port, one read port with registered read data.
module srft_mem #(
  parameter int ENTRIES = 128,
  parameter int AW      = 7
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  srft_pkg::srft_entry_t wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output srft_pkg::srft_entry_t rdata
);
  import srft_pkg::*;

  srft_entry_t mem [ENTRIES];
  srft_entry_t rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/srft_ctrl.sv @@
// Controller: walks the entry memory, decides the verdict and writes entries back.
module srft_ctrl #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srft_pkg::srft_cfg_t           cfg,
  srft_in_if.sink                       in_ch,
  srft_out_if.source                    out_ch,
  output logic                          mem_we,
  output logic [$clog2(2*TABLE_DEPTH)-1:0] mem_waddr,
  output srft_pkg::srft_entry_t         mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(2*TABLE_DEPTH)-1:0] mem_raddr,
  input  srft_pkg::srft_entry_t         mem_rdata
);
  import srft_pkg::*;

  localparam int SLOTS = 2 * TABLE_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int KW    = (CW > 7) ? CW : 7;

  srft_state_t state_r, state_nxt;

  // Walk control.
  logic [AW-1:0] rd_addr_r, last_addr_r, proc_addr_r;
  logic          issue_r, proc_r;

  // Latched item.
  logic [1:0]         type_r;
  logic [31:0]        key_r, now_r;
  logic signed [31:0] seq_r;

  // Walk results.
  logic               hit_found_r, free_found_r, old_found_r;
  logic [AW-1:0]      hit_addr_r, free_addr_r, old_addr_r;
  logic signed [31:0] hit_seq_r;
  logic [CW-1:0]      count_r;
  logic [31:0]        old_age_r, old_key_r;

  // Result being built and the output register.
  logic [1:0] verdict_r;
  logic       evicted_r;
  logic [7:0] removed_r;
  logic       out_valid_r;
  logic [1:0] out_verdict_r;
  logic       out_evicted_r;
  logic [7:0] out_removed_r;

  logic in_accept, in_is_check, is_sweep, out_load, wr_valid;

  // Per-entry evaluation during the walk.
  logic [31:0] e_age, cand_age;
  logic        e_stale, e_match, e_clear, e_hit, e_live, cand_better;

  // Decision terms.
  logic [KW-1:0] max_ext, cap, cnt_ext;
  logic          over_hit, full_ins, replay, new_loses;

  assign in_accept   = in_ch.valid && in_ch.ready;
  assign in_is_check = (in_ch.req_type == REQ_CHECK_REQ) || (in_ch.req_type == REQ_CHECK_REP);
  assign is_sweep    = !((type_r == REQ_CHECK_REQ) || (type_r == REQ_CHECK_REP));
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Age, staleness and match of the entry returned by the memory.
  always_comb begin
    e_age       = now_r - mem_rdata.stamp;
    e_stale     = e_age > cfg.entry_timeout;
    e_match     = mem_rdata.valid && (mem_rdata.key == key_r) && !hit_found_r;
    e_clear     = proc_r && (is_sweep ? (mem_rdata.valid && e_stale) : (e_match && e_stale));
    e_hit       = proc_r && !is_sweep && e_match && !e_stale;
    e_live      = mem_rdata.valid && !e_clear;
    cand_age    = e_hit ? 32'd0 : e_age;
    cand_better = !old_found_r || srft_older(cand_age, mem_rdata.key, old_age_r, old_key_r);
  end

  // Capacity limit clamped to one up to the table depth, and the verdict terms.
  always_comb begin
    max_ext = KW'(cfg.max_entries);
    cnt_ext = KW'(count_r);
    if (max_ext == '0) begin
      cap = KW'(1);
    end else if (max_ext > KW'(TABLE_DEPTH)) begin
      cap = KW'(TABLE_DEPTH);
    end else begin
      cap = max_ext;
    end
    over_hit  = cnt_ext > cap;
    full_ins  = (cnt_ext >= cap) || !free_found_r;
    replay    = seq_r <= hit_seq_r;
    new_loses = !old_found_r || ((old_age_r == 32'd0) && (key_r < old_key_r));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (rd_addr_r == AW'(SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_is_check && !in_ch.sig_ok) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (proc_r && (proc_addr_r == last_addr_r)) begin
          state_nxt = is_sweep ? ST_DONE : ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit_found_r) begin
          state_nxt = replay ? ST_DONE : ST_WR_HIT;
        end else if (full_ins) begin
          state_nxt = new_loses ? ST_DONE : ST_EVICT;
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_WR_HIT: state_nxt = over_hit ? ST_EVICT : ST_DONE;
      ST_EVICT:  state_nxt = hit_found_r ? ST_DONE : ST_INSERT;
      ST_INSERT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = proc_addr_r;
    wr_valid  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = rd_addr_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = rd_addr_r;
      end
      ST_WALK: begin
        mem_re = issue_r;
        mem_we = e_clear;
      end
      ST_WR_HIT: begin
        mem_we    = 1'b1;
        mem_waddr = hit_addr_r;
        wr_valid  = 1'b1;
      end
      ST_EVICT: begin
        mem_we    = 1'b1;
        mem_waddr = old_addr_r;
      end
      ST_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = free_found_r ? free_addr_r : old_addr_r;
        wr_valid  = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    mem_wdata.valid = wr_valid;
    mem_wdata.key   = key_r;
    mem_wdata.seq   = seq_r;
    mem_wdata.stamp = now_r;
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.verdict       = out_verdict_r;
  assign out_ch.evicted       = out_evicted_r;
  assign out_ch.removed_count = out_removed_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rd_addr_r   <= '0;
      issue_r     <= 1'b0;
      proc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      proc_r  <= (state_r == ST_WALK) && issue_r;

      // Clearing pass after reset steps one entry per cycle.
      if ((state_r == ST_CLEAR) && (rd_addr_r != AW'(SLOTS - 1))) begin
        rd_addr_r <= rd_addr_r + AW'(1);
      end

      // Start of an item: pick the address range of the walk.
      if (in_accept) begin
        issue_r   <= !(in_is_check && !in_ch.sig_ok);
        rd_addr_r <= (in_ch.req_type == REQ_CHECK_REP) ? AW'(TABLE_DEPTH) : '0;
      end

      // Read issue during the walk.
      if ((state_r == ST_WALK) && issue_r) begin
        if (rd_addr_r == last_addr_r) begin
          issue_r <= 1'b0;
        end else begin
          rd_addr_r <= rd_addr_r + AW'(1);
        end
      end

      // Output register: load a finished result, drop it once taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item, walk and result payload registers.
  always_ff @(posedge clk) begin
    proc_addr_r <= rd_addr_r;

    if (in_accept) begin
      type_r       <= in_ch.req_type;
      key_r        <= in_ch.key_address;
      seq_r        <= in_ch.seq_num;
      now_r        <= in_ch.now;
      last_addr_r  <= (in_ch.req_type == REQ_CHECK_REQ) ? AW'(TABLE_DEPTH - 1) : AW'(SLOTS - 1);
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      old_found_r  <= 1'b0;
      count_r      <= '0;
      evicted_r    <= 1'b0;
      removed_r    <= '0;
      if (!in_is_check) begin
        verdict_r <= VERDICT_SWEEP;
      end else if (!in_ch.sig_ok) begin
        verdict_r <= VERDICT_BAD_SIG;
      end else begin
        verdict_r <= VERDICT_ACCEPT;
      end
    end

    // One entry evaluated per cycle of the walk.
    if ((state_r == ST_WALK) && proc_r) begin
      if (is_sweep) begin
        if (e_clear && (removed_r != REMOVED_MAX)) begin
          removed_r <= removed_r + 8'd1;
        end
      end else begin
        if (e_hit) begin
          hit_found_r <= 1'b1;
          hit_addr_r  <= proc_addr_r;
          hit_seq_r   <= mem_rdata.seq;
        end
        if (e_live) begin
          count_r <= count_r + CW'(1);
          if (cand_better) begin
            old_found_r <= 1'b1;
            old_addr_r  <= proc_addr_r;
            old_age_r   <= cand_age;
            old_key_r   <= mem_rdata.key;
          end
        end else if (!free_found_r) begin
          free_found_r <= 1'b1;
          free_addr_r  <= proc_addr_r;
        end
      end
    end

    // Verdict and eviction flag.
    if (state_r == ST_DECIDE) begin
      if (hit_found_r && replay) begin
        verdict_r <= VERDICT_REPLAY;
      end
      if (!hit_found_r && full_ins) begin
        evicted_r <= 1'b1;
      end
    end
    if ((state_r == ST_WR_HIT) && over_hit) begin
      evicted_r <= 1'b1;
    end

    if (out_load) begin
      out_verdict_r <= verdict_r;
      out_evicted_r <= evicted_r;
      out_removed_r <= removed_r;
    end
  end

endmodule
